>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame sync finder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/mafs_pkg.sv
// ---------------------------------------------------------------------------
// mafs_pkg
// Types and constants shared by the MPEG audio frame sync finder.
// ---------------------------------------------------------------------------
package mafs_pkg;

   // search phases
   localparam logic [2:0] PH_COLLECT_FIRST     = 3'd0;
   localparam logic [2:0] PH_TAG_HEADER        = 3'd1;
   localparam logic [2:0] PH_TAG_SKIP          = 3'd2;
   localparam logic [2:0] PH_COLLECT_AFTER_TAG = 3'd3;
   localparam logic [2:0] PH_AID_LEN           = 3'd4;
   localparam logic [2:0] PH_AID_SKIP          = 3'd5;
   localparam logic [2:0] PH_SCAN              = 3'd6;
   localparam logic [2:0] PH_DONE              = 3'd7;

   localparam int unsigned COUNT_W = 28;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] AID_MARK = 32'h4169_4401;
   localparam logic [23:0] ID3_MARK = 24'h49_4433;
   localparam logic [31:0] TAG_HDR_LEN = 32'd10;
   localparam logic [15:0] AID_HDR_LEN = 16'd6;

   // expected_layer register values
   localparam logic [1:0] LAYER_1 = 2'd1;
   localparam logic [1:0] LAYER_2 = 2'd2;
   localparam logic [1:0] LAYER_3 = 2'd3;
   localparam logic [1:0] LAYER_RESET = LAYER_3;

   // layer field codes in header byte 1, bits 2:1
   localparam logic [1:0] LCODE_L1 = 2'b11;
   localparam logic [1:0] LCODE_L2 = 2'b10;
   localparam logic [1:0] LCODE_L3 = 2'b01;

   localparam logic [1:0] VER_RESERVED = 2'b01;
   localparam logic [1:0] VER_MPEG1    = 2'b11;
   localparam logic [1:0] EMPH_RESERVED = 2'b10;

   // forbidden channel-mode mask per bitrate index for MPEG-1 layer II
   localparam logic [3:0] L2_FORBIDDEN [16] = '{
      4'd0, 4'd7, 4'd7, 4'd7, 4'd0, 4'd7, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
   };

   typedef struct packed {
      logic step;     // data byte transfer
      logic restart;  // restart transfer
   } req_ctl_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] header;
      logic [31:0] offset;
      logic [31:0] tag_end;
      logic        free_format;
   } hit_type;

endpackage

>>> rtl/mafs_hdr_check.sv
// ---------------------------------------------------------------------------
// mafs_hdr_check
// Validity check of a 4-byte MPEG audio frame header candidate.
// ---------------------------------------------------------------------------
module mafs_hdr_check
   import mafs_pkg::*;
(
   input  logic [31:0] window,
   input  logic [1:0]  expected_layer,
   output logic        header_ok
);

   logic [7:0] b0, b1, b2, b3;
   logic [1:0] want_code;
   logic       layer_valid;
   logic [1:0] lay;
   logic [3:0] forbid;
   logic       l2_conflict;

   assign b0  = window[31:24];
   assign b1  = window[23:16];
   assign b2  = window[15:8];
   assign b3  = window[7:0];
   assign lay = b1[2:1];

   always_comb begin
      want_code   = LCODE_L3;
      layer_valid = 1'b1;
      unique case (expected_layer)
         LAYER_1: want_code = LCODE_L1;
         LAYER_2: want_code = LCODE_L2;
         LAYER_3: want_code = LCODE_L3;
         default: layer_valid = 1'b0;
      endcase
   end

   assign forbid      = L2_FORBIDDEN[b2[7:4]];
   assign l2_conflict = (b1[4:3] == VER_MPEG1) && (lay == LCODE_L2) && forbid[b3[7:6]];

   assign header_ok = (b0 == 8'hFF) && (b1[7:5] == 3'b111) && (b1[4:3] != VER_RESERVED)
                   && layer_valid && (lay == want_code) && (b2[7:4] != 4'hF)
                   && (b2[3:2] != 2'b11) && !l2_conflict && (b3[1:0] != EMPH_RESERVED);

endmodule

>>> rtl/mafs_scanner.sv
// ---------------------------------------------------------------------------
// mafs_scanner
// Search state: tag and AiD skipping, sliding header window, positions.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mafs_scanner
   import mafs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_ctl_type ctl,
   input  logic [7:0]  data_byte,
   input  logic [1:0]  expected_layer,
   output hit_type     hit
);

   logic [2:0]         phase_ff, phase_in;
   logic [31:0]        window_ff, window_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        pos_ff, pos_in;
   logic [31:0]        tag_end_ff, tag_end_in;

   logic [31:0]        shifted;
   logic [31:0]        tag_win;
   logic [15:0]        aid_len;
   logic [COUNT_W-1:0] count_inc, count_dec;
   logic               hdr_ok;

   assign shifted   = {window_ff[23:0], data_byte};
   assign tag_win   = {window_ff[24:0], data_byte[6:0]};
   assign aid_len   = {data_byte, window_ff[7:0]};
   assign count_inc = count_ff + 1'b1;
   assign count_dec = (count_ff != '0) ? count_ff - 1'b1 : count_ff;

   mafs_hdr_check u_hdr_check (
      .window         (shifted),
      .expected_layer (expected_layer),
      .header_ok      (hdr_ok)
   );

   always_comb begin
      phase_in   = phase_ff;
      window_in  = window_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      tag_end_in = tag_end_ff;
      hit        = '0;
      if (ctl.restart) begin
         phase_in   = PH_COLLECT_FIRST;
         window_in  = '0;
         count_in   = '0;
         pos_in     = '0;
         tag_end_in = '0;
      end else if (ctl.step) begin
         if (pos_ff != ALL_ONES) begin
            pos_in = pos_ff + 32'd1;
         end
         unique case (phase_ff)
            PH_COLLECT_FIRST, PH_COLLECT_AFTER_TAG, PH_SCAN: begin
               window_in = shifted;
               if (phase_ff != PH_SCAN || count_ff < COUNT_W'(4)) begin
                  count_in = count_inc;
               end
               if (count_in >= COUNT_W'(4)) begin
                  if (phase_ff == PH_COLLECT_FIRST && shifted[31:8] == ID3_MARK) begin
                     phase_in  = PH_TAG_HEADER;
                     count_in  = '0;
                     window_in = '0;
                  end else if (phase_ff != PH_SCAN && shifted == AID_MARK) begin
                     phase_in  = PH_AID_LEN;
                     count_in  = '0;
                     window_in = '0;
                  end else if (hdr_ok) begin
                     phase_in  = PH_DONE;
                     hit.valid = 1'b1;
                  end else begin
                     phase_in = PH_SCAN;
                     count_in = COUNT_W'(4);
                  end
               end
            end
            PH_TAG_HEADER: begin
               if (count_ff >= COUNT_W'(2)) begin
                  window_in = tag_win;
               end
               count_in = count_inc;
               if (count_inc >= COUNT_W'(6)) begin
                  tag_end_in = TAG_HDR_LEN + window_in;
                  if (window_in == '0) begin
                     phase_in = PH_COLLECT_AFTER_TAG;
                     count_in = '0;
                  end else begin
                     phase_in = PH_TAG_SKIP;
                     count_in = window_in[COUNT_W-1:0];
                  end
                  window_in = '0;
               end
            end
            PH_TAG_SKIP: begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  phase_in  = PH_COLLECT_AFTER_TAG;
                  window_in = '0;
               end
            end
            PH_AID_LEN: begin
               if (count_ff == '0) begin
                  window_in = {24'd0, data_byte};
                  count_in  = COUNT_W'(1);
               end else if (aid_len > AID_HDR_LEN) begin
                  phase_in  = PH_AID_SKIP;
                  count_in  = COUNT_W'(aid_len - AID_HDR_LEN);
                  window_in = '0;
               end else begin
                  phase_in  = PH_SCAN;
                  count_in  = '0;
                  window_in = '0;
               end
            end
            PH_AID_SKIP: begin
               count_in = count_dec;
               if (count_dec == '0) begin
                  phase_in  = PH_SCAN;
                  window_in = '0;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
      // offset counts the header's first byte from the advanced position
      hit.header      = shifted;
      hit.offset      = (pos_in == ALL_ONES) ? ALL_ONES : pos_in - 32'd4;
      hit.tag_end     = tag_end_ff;
      hit.free_format = (shifted[15:12] == 4'h0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_COLLECT_FIRST;
         window_ff  <= '0;
         count_ff   <= '0;
         pos_ff     <= '0;
         tag_end_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         count_ff   <= count_in;
         pos_ff     <= pos_in;
         tag_end_ff <= tag_end_in;
      end
   end

   `ASSERT_NEXT(a_hit_then_done, clock, reset, hit.valid, phase_ff == PH_DONE)
   `ASSERT_NEXT(a_done_holds, clock, reset, phase_ff == PH_DONE && !ctl.restart,
                phase_ff == PH_DONE)
   `ASSERT_NEXT(a_pos_saturates, clock, reset, pos_ff == ALL_ONES && !ctl.restart,
                pos_ff == ALL_ONES)

endmodule

>>> rtl/mpeg_audio_frame_sync_finder_core.sv
// ---------------------------------------------------------------------------
// mpeg_audio_frame_sync_finder_core
// Locates the first valid MPEG audio frame header in a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : stream input. req_tdata carries one stream byte, req_tuser says
//            whether the transfer is a data byte (0) or a restart (1). A
//            restart clears the search state and consumes no byte.
//   rsp_*  : one transfer per header found: header word, its byte offset,
//            the end offset of a leading ID3v2 tag, and the free-format flag.
//   csr_*  : write of expected_layer (1..3); write only while idle.
// The block skips a leading ID3v2 tag and an optional AiD block, then slides
// a 4-byte window until the header checks pass. After a find, data bytes are
// dropped until a restart.
// Throughput: one input transfer per clock while req_tready is high. Each
// byte updates the search state; the result lands in the output register
// in the cycle after the byte that completes the header.
// Reset: search state clears, expected_layer returns to 3, output empties.
// Stall: when the output register holds a result and rsp_tready is low,
// req_tready drops; it stays high whenever the output register is empty or
// being drained in the same cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mpeg_audio_frame_sync_finder_core
   import mafs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] kind
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] frame_header, [63:32] header_offset,
                                    // [95:64] tag_end_offset
   output logic        rsp_tuser,   // [0] free_format
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data     // expected_layer
);

   logic [1:0]  expected_layer_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff;
   logic        rsp_user_ff;
   req_ctl_type ctl;
   hit_type     hit;
   logic        req_xfer;

   // accept input whenever the output register is free or draining now
   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign req_xfer    = req_tvalid && req_tready;
   assign ctl         = '{step: req_xfer && !req_tuser, restart: req_xfer && req_tuser};
   assign csr_ready   = 1'b1;

   mafs_scanner u_scanner (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .data_byte      (req_tdata),
      .expected_layer (expected_layer_ff),
      .hit            (hit)
   );

   // hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (hit.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         expected_layer_ff <= LAYER_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            expected_layer_ff <= csr_data;
         end
      end
   end

   // payload: load on a find, no reset needed
   always_ff @(posedge clock) begin
      if (hit.valid) begin
         rsp_data_ff <= {hit.tag_end, hit.offset, hit.header};
         rsp_user_ff <= hit.free_format;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_IMPL(a_stall_only_when_full, clock, reset, !req_tready, rsp_valid_ff && !rsp_tready)

endmodule
